FILE: sv/matrix_2x2_unit_assert.svh
// Assertion shorthands for the matrix unit RTL; only the queue uses them.
// Each macro expects clk and rst_n in scope.
`ifndef MATRIX_2X2_UNIT_ASSERT_SVH
`define MATRIX_2X2_UNIT_ASSERT_SVH

// Condition must hold at every clock edge out of reset.
`define M2U_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define M2U_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/m2u_pkg.sv
package m2u_pkg;

    localparam int DATA_W = 32;

    // Opcodes as seen on the cmd port
    localparam logic [2:0] CMD_DET   = 3'd0;
    localparam logic [2:0] CMD_PAIR  = 3'd1;
    localparam logic [2:0] CMD_TRANS = 3'd2;
    localparam logic [2:0] CMD_INV   = 3'd3;
    localparam logic [2:0] CMD_MV    = 3'd4;
    localparam logic [2:0] CMD_MM    = 3'd5;

    typedef enum logic [2:0] {
        OP_DET,
        OP_PAIR,
        OP_TRANS,
        OP_INV,
        OP_MV,
        OP_MM,
        OP_NONE
    } op_t;

    typedef logic signed [DATA_W-1:0] word_t;

    localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        op_t   op;
        word_t a;
        word_t b;
        word_t c;
        word_t d;
        word_t e;
        word_t f;
        word_t g;
        word_t h;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    localparam int QDEPTH = 2;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int CNT_W  = $clog2(QDEPTH + 1);

endpackage

FILE: sv/m2u_fifo.sv
`include "matrix_2x2_unit_assert.svh"

module m2u_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  m2u_pkg::item_t    push_item,
    input  logic              pop,
    output m2u_pkg::item_t    head,
    output m2u_pkg::q_status_t q_status
);
    import m2u_pkg::*;

    item_t            mem_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head           = mem_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == CNT_W'(QDEPTH));
    assign q_status.empty = (count_reg == '0);

    `M2U_ASSERT_ALWAYS(a_no_overrun, !(push && count_reg == CNT_W'(QDEPTH)), "push into full queue")
    `M2U_ASSERT_ALWAYS(a_no_underrun, !(pop && count_reg == '0), "pop from empty queue")
    `M2U_ASSERT_NEXT(a_fill_track, push && !pop, count_reg == $past(count_reg) + 1'b1, "count lost a beat")

endmodule

FILE: sv/m2u_front.sv
module m2u_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [2:0]         cmd,
    input  m2u_pkg::word_t     m_a,
    input  m2u_pkg::word_t     m_b,
    input  m2u_pkg::word_t     m_c,
    input  m2u_pkg::word_t     m_d,
    input  m2u_pkg::word_t     second_a,
    input  m2u_pkg::word_t     second_b,
    input  m2u_pkg::word_t     second_c,
    input  m2u_pkg::word_t     second_d,
    output logic               push,
    output m2u_pkg::item_t     push_item,
    input  m2u_pkg::q_status_t q_status
);
    import m2u_pkg::*;

    logic  front_valid_reg, front_valid_next;
    item_t front_item_reg;
    logic  load;
    op_t   op_dec;

    always_comb
    begin
        unique case (cmd)
            CMD_DET:   op_dec = OP_DET;
            CMD_PAIR:  op_dec = OP_PAIR;
            CMD_TRANS: op_dec = OP_TRANS;
            CMD_INV:   op_dec = OP_INV;
            CMD_MV:    op_dec = OP_MV;
            CMD_MM:    op_dec = OP_MM;
            default:   op_dec = OP_NONE;
        endcase
    end

    assign item_stall       = front_valid_reg && q_status.full;
    assign push             = front_valid_reg && !q_status.full;
    assign load             = item_valid && !item_stall;
    assign front_valid_next = load || (front_valid_reg && !push);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            front_item_reg <= '{op: op_dec, a: m_a, b: m_b, c: m_c, d: m_d,
                                e: second_a, f: second_b, g: second_c, h: second_d};
        end
    end

    assign push_item = front_item_reg;

endmodule

FILE: sv/m2u_back.sv
module m2u_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  m2u_pkg::q_status_t q_status,
    input  m2u_pkg::item_t     head,
    output logic               pop,
    output logic               res_valid,
    input  logic               res_stall,
    output m2u_pkg::word_t     res_0,
    output m2u_pkg::word_t     res_1,
    output m2u_pkg::word_t     res_2,
    output m2u_pkg::word_t     res_3,
    output logic               singular,
    output logic               overflow
);
    import m2u_pkg::*;

    localparam int DW = DATA_W + FRAC_BITS;   // dividend / quotient magnitude width
    localparam int PW = 2 * DATA_W;           // product width
    localparam int SW = PW + 2;               // exact sum width

    logic adv;

    // multiply stage
    logic                 m_valid_reg;
    op_t                  m_op_reg;
    logic signed [PW-1:0] m_p_reg [8];
    word_t                m_orig_reg [4];
    word_t                opx [8];
    word_t                opy [8];

    // sum, shift, saturate
    logic signed [SW-1:0] s_sum [4];
    logic signed [SW-1:0] s_shf [4];
    word_t                s_val [4];
    logic                 s_sat [4];
    logic                 s_sub;
    word_t                s_r_next [4];
    logic                 s_ovf_next, s_sing_next, s_div_next;
    logic [DATA_W-1:0]    s_dvs_next;
    logic [DW-1:0]        s_qd_next [4];
    logic                 s_neg_next [4];
    logic signed [DATA_W:0] s_num [4];
    logic [DATA_W:0]      s_mag [4];

    // divider stages, index 0 is the sum stage output
    logic              d_valid_reg [DW+1];
    logic              d_div_reg   [DW+1];
    logic              d_sing_reg  [DW+1];
    logic              d_ovf_reg   [DW+1];
    word_t             d_r_reg     [DW+1][4];
    logic [DATA_W-1:0] d_dvs_reg   [DW+1];
    logic [DATA_W-1:0] d_rem_reg   [DW+1][4];
    logic [DW-1:0]     d_qd_reg    [DW+1][4];
    logic              d_neg_reg   [DW+1][4];

    logic [DATA_W:0]   st_t   [DW][4];
    logic              st_ge  [DW][4];
    logic [DATA_W-1:0] st_rem [DW][4];
    logic [DW-1:0]     st_qd  [DW][4];

    // final sign and saturation of quotients
    word_t fin_val [4];
    logic  fin_sat [4];
    word_t fin_r [4];
    logic  fin_ovf;

    // output register
    logic  res_valid_reg, res_valid_next;
    word_t res_r_reg [4];
    logic  singular_reg, overflow_reg;

    assign adv = !res_valid_reg || !res_stall;
    assign pop = adv && !q_status.empty;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            opx[i] = '0;
            opy[i] = '0;
        end
        unique case (head.op)
            OP_DET, OP_INV:
            begin
                opx[0] = head.a; opy[0] = head.d;
                opx[1] = head.b; opy[1] = head.c;
            end
            OP_PAIR:
            begin
                opx[0] = head.a; opy[0] = head.d;
                opx[2] = head.b; opy[2] = head.c;
            end
            OP_MV:
            begin
                opx[0] = head.a; opy[0] = head.e;
                opx[1] = head.b; opy[1] = head.f;
                opx[2] = head.c; opy[2] = head.e;
                opx[3] = head.d; opy[3] = head.f;
            end
            OP_MM:
            begin
                opx[0] = head.a; opy[0] = head.e;
                opx[1] = head.b; opy[1] = head.g;
                opx[2] = head.a; opy[2] = head.f;
                opx[3] = head.b; opy[3] = head.h;
                opx[4] = head.c; opy[4] = head.e;
                opx[5] = head.d; opy[5] = head.g;
                opx[6] = head.c; opy[6] = head.f;
                opx[7] = head.d; opy[7] = head.h;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_op_reg      <= head.op;
            m_orig_reg[0] <= head.a;
            m_orig_reg[1] <= head.b;
            m_orig_reg[2] <= head.c;
            m_orig_reg[3] <= head.d;
            for (int i = 0; i < 8; i++)
            begin
                m_p_reg[i] <= opx[i] * opy[i];
            end
        end
    end

    assign s_sub = (m_op_reg == OP_DET) || (m_op_reg == OP_INV);

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            s_sum[k] = SW'(m_p_reg[2*k]) +
                       (s_sub ? -SW'(m_p_reg[2*k+1]) : SW'(m_p_reg[2*k+1]));
            s_shf[k] = s_sum[k] >>> FRAC_BITS;
            s_sat[k] = !((&s_shf[k][SW-1:DATA_W-1]) || !(|s_shf[k][SW-1:DATA_W-1]));
            s_val[k] = s_sat[k] ? (s_shf[k][SW-1] ? WORD_MIN : WORD_MAX)
                                : s_shf[k][DATA_W-1:0];
        end
    end

    // inverse: numerators d, -b, -c, a over |det|
    always_comb
    begin
        s_num[0] = (DATA_W+1)'(m_orig_reg[3]);
        s_num[1] = -(DATA_W+1)'(m_orig_reg[1]);
        s_num[2] = -(DATA_W+1)'(m_orig_reg[2]);
        s_num[3] = (DATA_W+1)'(m_orig_reg[0]);
        s_dvs_next = s_val[0][DATA_W-1] ? -s_val[0] : s_val[0];
        for (int k = 0; k < 4; k++)
        begin
            s_mag[k]      = s_num[k][DATA_W] ? -s_num[k] : s_num[k];
            s_qd_next[k]  = {s_mag[k][DATA_W-1:0], {FRAC_BITS{1'b0}}};
            s_neg_next[k] = s_num[k][DATA_W] ^ s_val[0][DATA_W-1];
        end
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            s_r_next[k] = '0;
        end
        s_ovf_next  = 1'b0;
        s_sing_next = 1'b0;
        s_div_next  = 1'b0;
        unique case (m_op_reg)
            OP_DET:
            begin
                s_r_next[0] = s_val[0];
                s_ovf_next  = s_sat[0];
            end
            OP_PAIR, OP_MV:
            begin
                s_r_next[0] = s_val[0];
                s_r_next[1] = s_val[1];
                s_ovf_next  = s_sat[0] || s_sat[1];
            end
            OP_MM:
            begin
                for (int k = 0; k < 4; k++)
                begin
                    s_r_next[k] = s_val[k];
                end
                s_ovf_next = s_sat[0] || s_sat[1] || s_sat[2] || s_sat[3];
            end
            OP_TRANS:
            begin
                s_r_next[0] = m_orig_reg[0];
                s_r_next[1] = m_orig_reg[2];
                s_r_next[2] = m_orig_reg[1];
                s_r_next[3] = m_orig_reg[3];
            end
            OP_INV:
            begin
                if (s_val[0] == '0)
                begin
                    // singular: matrix back unchanged, no overflow
                    for (int k = 0; k < 4; k++)
                    begin
                        s_r_next[k] = m_orig_reg[k];
                    end
                    s_sing_next = 1'b1;
                end
                else
                begin
                    s_div_next = 1'b1;
                    s_ovf_next = s_sat[0];
                end
            end
            default:
            begin
            end
        endcase
    end

    // one restoring step per stage, four lanes
    always_comb
    begin
        for (int j = 0; j < DW; j++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                st_t[j][k]   = {d_rem_reg[j][k], d_qd_reg[j][k][DW-1]};
                st_ge[j][k]  = (st_t[j][k] >= {1'b0, d_dvs_reg[j]});
                st_rem[j][k] = st_ge[j][k] ? DATA_W'(st_t[j][k] - {1'b0, d_dvs_reg[j]})
                                           : st_t[j][k][DATA_W-1:0];
                st_qd[j][k]  = {d_qd_reg[j][k][DW-2:0], st_ge[j][k]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            for (int j = 0; j <= DW; j++)
            begin
                d_valid_reg[j] <= 1'b0;
            end
        end
        else if (adv)
        begin
            m_valid_reg    <= !q_status.empty;
            d_valid_reg[0] <= m_valid_reg;
            for (int j = 1; j <= DW; j++)
            begin
                d_valid_reg[j] <= d_valid_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_div_reg[0]  <= s_div_next;
            d_sing_reg[0] <= s_sing_next;
            d_ovf_reg[0]  <= s_ovf_next;
            d_dvs_reg[0]  <= s_dvs_next;
            for (int k = 0; k < 4; k++)
            begin
                d_r_reg[0][k]   <= s_r_next[k];
                d_rem_reg[0][k] <= '0;
                d_qd_reg[0][k]  <= s_qd_next[k];
                d_neg_reg[0][k] <= s_neg_next[k];
            end
            for (int j = 1; j <= DW; j++)
            begin
                d_div_reg[j]  <= d_div_reg[j-1];
                d_sing_reg[j] <= d_sing_reg[j-1];
                d_ovf_reg[j]  <= d_ovf_reg[j-1];
                d_dvs_reg[j]  <= d_dvs_reg[j-1];
                for (int k = 0; k < 4; k++)
                begin
                    d_r_reg[j][k]   <= d_r_reg[j-1][k];
                    d_rem_reg[j][k] <= st_rem[j-1][k];
                    d_qd_reg[j][k]  <= st_qd[j-1][k];
                    d_neg_reg[j][k] <= d_neg_reg[j-1][k];
                end
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (d_neg_reg[DW][k])
            begin
                fin_sat[k] = (|d_qd_reg[DW][k][DW-1:DATA_W]) ||
                             (d_qd_reg[DW][k][DATA_W-1] && (|d_qd_reg[DW][k][DATA_W-2:0]));
                fin_val[k] = fin_sat[k] ? WORD_MIN : -d_qd_reg[DW][k][DATA_W-1:0];
            end
            else
            begin
                fin_sat[k] = |d_qd_reg[DW][k][DW-1:DATA_W-1];
                fin_val[k] = fin_sat[k] ? WORD_MAX : d_qd_reg[DW][k][DATA_W-1:0];
            end
            fin_r[k] = d_div_reg[DW] ? fin_val[k] : d_r_reg[DW][k];
        end
        fin_ovf = d_ovf_reg[DW] ||
                  (d_div_reg[DW] && (fin_sat[0] || fin_sat[1] || fin_sat[2] || fin_sat[3]));
    end

    assign res_valid_next = adv ? d_valid_reg[DW] : res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && d_valid_reg[DW])
        begin
            for (int k = 0; k < 4; k++)
            begin
                res_r_reg[k] <= fin_r[k];
            end
            singular_reg <= d_sing_reg[DW];
            overflow_reg <= fin_ovf;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_0     = res_r_reg[0];
    assign res_1     = res_r_reg[1];
    assign res_2     = res_r_reg[2];
    assign res_3     = res_r_reg[3];
    assign singular  = singular_reg;
    assign overflow  = overflow_reg;

endmodule

FILE: sv/matrix_2x2_unit.sv
// 2x2 matrix unit, signed fixed point with FRAC_BITS fraction bits (Q16.16 by
// default). One beat on the item channel carries cmd and two matrices (or a
// matrix and a vector); exactly one beat comes back on the result channel, in
// order. A new item is taken every cycle while item_stall is low. A result
// passes the front register, queue, multiply and sum stages, inverse divider
// (one quotient bit per stage in four lanes) and output register. Every
// operation walks the same pipeline so ordering is free. res_stall freezes
// the back end; the two-entry queue and the front register then fill before
// item_stall rises. Products are floored to fixed point (Q16.16 by default)
// and saturated; overflow reports any clamp, singular a zero determinant on
// inverse (matrix returned unchanged). Unused opcodes give zeros.
module matrix_2x2_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    // item channel
    input  logic           item_valid,
    output logic           item_stall,
    input  logic [2:0]     cmd,
    input  m2u_pkg::word_t m_a,
    input  m2u_pkg::word_t m_b,
    input  m2u_pkg::word_t m_c,
    input  m2u_pkg::word_t m_d,
    input  m2u_pkg::word_t second_a,
    input  m2u_pkg::word_t second_b,
    input  m2u_pkg::word_t second_c,
    input  m2u_pkg::word_t second_d,
    // result channel
    output logic           res_valid,
    input  logic           res_stall,
    output m2u_pkg::word_t res_0,
    output m2u_pkg::word_t res_1,
    output m2u_pkg::word_t res_2,
    output m2u_pkg::word_t res_3,
    output logic           singular,
    output logic           overflow
);
    import m2u_pkg::*;

    // front to queue
    logic      push;
    item_t     push_item;
    // queue to back end
    item_t     head;
    q_status_t q_status;
    logic      pop;

    // front: takes the beat, decodes cmd into an operation class
    m2u_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .cmd        (cmd),
        .m_a        (m_a),
        .m_b        (m_b),
        .m_c        (m_c),
        .m_d        (m_d),
        .second_a   (second_a),
        .second_b   (second_b),
        .second_c   (second_c),
        .second_d   (second_d),
        .push       (push),
        .push_item  (push_item),
        .q_status   (q_status)
    );

    // short queue decoupling the two halves
    m2u_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .q_status  (q_status)
    );

    // back end: multipliers, sum/saturate, pipelined divider, output register
    m2u_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .head      (head),
        .pop       (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_0     (res_0),
        .res_1     (res_1),
        .res_2     (res_2),
        .res_3     (res_3),
        .singular  (singular),
        .overflow  (overflow)
    );

endmodule
